### rtl/core/tksd_pkg.sv
// Package for the terminal key sequence decoder: parse phases, sequencer
// states, key codes, byte constants and the structs shared by the modules.
// No dependencies.
package tksd_pkg;

  localparam int STORE_BYTES_DEF = 64;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ESC     = 3'd1,
    PH_CSI_NUM = 3'd2,
    PH_CSI_MOD = 3'd3,
    PH_SS3     = 3'd4,
    PH_UTF8    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_STEP  = 3'd1,
    S_TMO   = 3'd2,
    S_RD    = 3'd3,
    S_LOAD  = 3'd4,
    S_FLUSH = 3'd5
  } seq_t;

  // key codes
  localparam logic [4:0] KEY_NONE      = 5'd0;
  localparam logic [4:0] KEY_CHAR      = 5'd1;
  localparam logic [4:0] KEY_ENTER     = 5'd2;
  localparam logic [4:0] KEY_TAB       = 5'd3;
  localparam logic [4:0] KEY_BACKSPACE = 5'd4;
  localparam logic [4:0] KEY_ESC       = 5'd5;
  localparam logic [4:0] KEY_CTRL_A    = 5'd6;
  localparam logic [4:0] KEY_CTRL_C    = 5'd7;
  localparam logic [4:0] KEY_CTRL_D    = 5'd8;
  localparam logic [4:0] KEY_CTRL_E    = 5'd9;
  localparam logic [4:0] KEY_CTRL_K    = 5'd10;
  localparam logic [4:0] KEY_CTRL_U    = 5'd11;
  localparam logic [4:0] KEY_CTRL_W    = 5'd12;
  localparam logic [4:0] KEY_UP        = 5'd13;
  localparam logic [4:0] KEY_DOWN      = 5'd14;
  localparam logic [4:0] KEY_RIGHT     = 5'd15;
  localparam logic [4:0] KEY_LEFT      = 5'd16;
  localparam logic [4:0] KEY_HOME      = 5'd17;
  localparam logic [4:0] KEY_END       = 5'd18;
  localparam logic [4:0] KEY_DELETE    = 5'd19;
  localparam logic [4:0] KEY_PGUP      = 5'd20;
  localparam logic [4:0] KEY_PGDN      = 5'd21;
  localparam logic [4:0] KEY_SH_PGUP   = 5'd22;
  localparam logic [4:0] KEY_SH_PGDN   = 5'd23;
  localparam logic [4:0] KEY_BACKTAB   = 5'd24;

  // input bytes of interest
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CA    = 8'h01;
  localparam logic [7:0] CH_CC    = 8'h03;
  localparam logic [7:0] CH_CD    = 8'h04;
  localparam logic [7:0] CH_CE    = 8'h05;
  localparam logic [7:0] CH_CK    = 8'h0b;
  localparam logic [7:0] CH_CU    = 8'h15;
  localparam logic [7:0] CH_CW    = 8'h17;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_O     = 8'h4f;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_Z     = 8'h5a;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] fnum;
    logic [1:0] snum;
    logic       fseen;
    logic [1:0] urem;
  } parse_t;

  localparam parse_t PARSE_CLR = '{phase: PH_IDLE, fnum: 4'd0, snum: 2'd0,
                                   fseen: 1'b0, urem: 2'd0};

  typedef struct packed {
    logic [4:0]  key;
    logic [20:0] cp;
    logic [31:0] bytes;
    logic [2:0]  len;
  } result_t;

  // what one decode step asks of the sequencer
  typedef struct packed {
    logic emit;     // step yields a key event
    logic wr;       // byte goes into the store
    logic again;    // decode the same byte afresh
    logic again_o;  // decode 'O', then the same byte
  } step_ctl_t;

endpackage

### rtl/core/tksd_step.sv
// One decode step of the key sequence parser: one byte against the parse
// state, giving the next state, at most one key event and store control.
// Depends on tksd_pkg.
module tksd_step import tksd_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF,
  parameter int CW = $clog2(STORE_BYTES + 1),
  parameter int AW = $clog2(STORE_BYTES)
) (
  input  parse_t          parse_in,
  input  logic [CW-1:0]   count_in,
  input  logic [3:0][7:0] ub_in,
  input  logic [7:0]      byte_in,
  output parse_t          parse_out,
  output logic [CW-1:0]   count_out,
  output logic [3:0][7:0] ub_out,
  output logic [AW-1:0]   wr_addr,
  output result_t         res,
  output step_ctl_t       ctl
);

  localparam logic [CW-1:0] FULL = CW'(STORE_BYTES);
  localparam logic [CW-1:0] FOUR = CW'(4);

  function automatic logic [4:0] csi_key(input logic [7:0] f, input logic [3:0] fnum,
                                         input logic [1:0] snum, input logic fseen);
    logic [4:0] k;
    k = KEY_NONE;
    if (f == CH_TILDE) begin
      case (fnum)
        4'd1, 4'd7: k = KEY_HOME;
        4'd3:       k = KEY_DELETE;
        4'd4, 4'd8: k = KEY_END;
        4'd5:       k = (snum == 2'd2) ? KEY_SH_PGUP : KEY_PGUP;
        4'd6:       k = (snum == 2'd2) ? KEY_SH_PGDN : KEY_PGDN;
        default:    k = KEY_NONE;
      endcase
    end else if (!fseen) begin
      case (f)
        CH_A:    k = KEY_UP;
        CH_B:    k = KEY_DOWN;
        CH_C:    k = KEY_RIGHT;
        CH_D:    k = KEY_LEFT;
        CH_H:    k = KEY_HOME;
        CH_F:    k = KEY_END;
        CH_Z:    k = KEY_BACKTAB;
        default: k = KEY_NONE;
      endcase
    end
    return k;
  endfunction

  parse_t          p;
  logic [CW-1:0]   cnt;
  logic [3:0][7:0] ub;
  logic            st;
  logic            is_digit;
  logic [7:0]      fn_acc;
  logic [5:0]      sn_acc;
  logic [2:0]      n;
  logic [7:0]      b0, b1, b2, b3;
  logic [4:0]      k;

  assign is_digit = (byte_in >= CH_0) && (byte_in <= CH_9);
  assign fn_acc   = 8'(parse_in.fnum) * 8'd10 + {4'd0, byte_in[3:0]};
  assign sn_acc   = 6'(parse_in.snum) * 6'd10 + {2'd0, byte_in[3:0]};

  always_comb begin
    p       = parse_in;
    cnt     = count_in;
    ub      = ub_in;
    st      = 1'b0;
    res     = '0;
    ctl     = '0;
    wr_addr = count_in[AW-1:0];
    n       = 3'd0;
    b0      = 8'd0;
    b1      = 8'd0;
    b2      = 8'd0;
    b3      = 8'd0;
    k       = KEY_NONE;

    // a pending sequence that filled the store is dropped
    if (p.phase != PH_IDLE && cnt >= FULL) begin
      p   = PARSE_CLR;
      cnt = '0;
    end
    wr_addr = cnt[AW-1:0];

    case (p.phase)
      PH_ESC: begin
        if (byte_in == CH_LBRK) begin
          st      = 1'b1;
          p.phase = PH_CSI_NUM;
        end else if (byte_in == CH_O) begin
          st      = 1'b1;
          p.phase = PH_SS3;
        end else begin
          res.key   = KEY_ESC;
          ctl.emit  = 1'b1;
          ctl.again = 1'b1;
          p         = PARSE_CLR;
          cnt       = '0;
        end
      end
      PH_SS3: begin
        if (byte_in == CH_H || byte_in == CH_F) begin
          res.key  = (byte_in == CH_H) ? KEY_HOME : KEY_END;
          ctl.emit = 1'b1;
        end else begin
          res.key     = KEY_ESC;
          ctl.emit    = 1'b1;
          ctl.again_o = 1'b1;
        end
        p   = PARSE_CLR;
        cnt = '0;
      end
      PH_CSI_NUM: begin
        if (is_digit) begin
          st      = 1'b1;
          p.fseen = 1'b1;
          p.fnum  = (fn_acc > 8'd15) ? 4'd15 : fn_acc[3:0];
        end else if (byte_in == CH_SEMI) begin
          st      = 1'b1;
          p.phase = PH_CSI_MOD;
        end else begin
          k        = csi_key(byte_in, p.fnum, p.snum, p.fseen);
          res.key  = k;
          ctl.emit = (k != KEY_NONE);
          p        = PARSE_CLR;
          cnt      = '0;
        end
      end
      PH_CSI_MOD: begin
        if (is_digit) begin
          st     = 1'b1;
          p.snum = (sn_acc > 6'd3) ? 2'd3 : sn_acc[1:0];
        end else begin
          k        = csi_key(byte_in, p.fnum, p.snum, p.fseen);
          res.key  = k;
          ctl.emit = (k != KEY_NONE);
          p        = PARSE_CLR;
          cnt      = '0;
        end
      end
      PH_UTF8: begin
        // store inline: the event below needs the updated bytes
        if (cnt < FULL) begin
          ctl.wr = 1'b1;
          if (cnt < FOUR) ub[cnt[1:0]] = byte_in;
          cnt = cnt + 1'b1;
        end
        if (p.urem != 2'd0) p.urem = p.urem - 2'd1;
        if (p.urem == 2'd0) begin
          n  = (cnt >= FOUR) ? 3'd4 : cnt[2:0];
          b0 = (n > 3'd0) ? ub[0] : 8'd0;
          b1 = (n > 3'd1) ? ub[1] : 8'd0;
          b2 = (n > 3'd2) ? ub[2] : 8'd0;
          b3 = (n > 3'd3) ? ub[3] : 8'd0;
          case (n)
            3'd0, 3'd1: res.cp = {13'd0, b0};
            3'd2:       res.cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3:       res.cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            default:    res.cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
          endcase
          res.key   = KEY_CHAR;
          res.bytes = {b3, b2, b1, b0};
          res.len   = n;
          ctl.emit  = 1'b1;
          p         = PARSE_CLR;
          cnt       = '0;
        end
      end
      default: begin
        p   = PARSE_CLR;
        cnt = '0;
        case (byte_in)
          CH_ESC: begin
            st      = 1'b1;
            p.phase = PH_ESC;
          end
          CH_CR, CH_LF: res.key = KEY_ENTER;
          CH_TAB:       res.key = KEY_TAB;
          CH_DEL, CH_BS: res.key = KEY_BACKSPACE;
          CH_CA:        res.key = KEY_CTRL_A;
          CH_CC:        res.key = KEY_CTRL_C;
          CH_CD:        res.key = KEY_CTRL_D;
          CH_CE:        res.key = KEY_CTRL_E;
          CH_CK:        res.key = KEY_CTRL_K;
          CH_CU:        res.key = KEY_CTRL_U;
          CH_CW:        res.key = KEY_CTRL_W;
          default: begin
            if (byte_in < CH_SPACE) begin
              res.key = KEY_NONE;
            end else if (!byte_in[7]) begin
              res.key   = KEY_CHAR;
              res.cp    = {13'd0, byte_in};
              res.bytes = {24'd0, byte_in};
              res.len   = 3'd1;
            end else if (byte_in[7:5] == 3'b110) begin
              st      = 1'b1;
              p.urem  = 2'd1;
              p.phase = PH_UTF8;
            end else if (byte_in[7:4] == 4'b1110) begin
              st      = 1'b1;
              p.urem  = 2'd2;
              p.phase = PH_UTF8;
            end else if (byte_in[7:3] == 5'b11110) begin
              st      = 1'b1;
              p.urem  = 2'd3;
              p.phase = PH_UTF8;
            end
          end
        endcase
        ctl.emit = (res.key != KEY_NONE);
      end
    endcase

    // plain store of a sequence byte
    if (st && cnt < FULL) begin
      ctl.wr = 1'b1;
      if (cnt < FOUR) ub[cnt[1:0]] = byte_in;
      cnt = cnt + 1'b1;
    end

    parse_out = p;
    count_out = cnt;
    ub_out    = ub;
  end

endmodule

### rtl/core/terminal_key_sequence_decoder.sv
// Terminal key sequence decoder: bytes or timeouts in, key events out.
// A byte goes through transfer, a decode step and the flush of the last
// event, plus one more decode step per byte decoded afresh; a timeout adds
// a store read, a load and a decode step per stored byte after the ESC. One
// item at a time; a stalled output holds the sequencer until the event moves on.
// Reset clears parse state, byte count and handshakes; store contents undefined.
module terminal_key_sequence_decoder import tksd_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  key_code,
  output logic [20:0] codepoint,
  output logic [31:0] utf8_bytes,
  output logic [2:0]  utf8_len,
  output logic        last
);

  localparam int CW = $clog2(STORE_BYTES + 1);
  localparam int AW = $clog2(STORE_BYTES);
  localparam result_t ESC_RES = '{key: KEY_ESC, cp: 21'd0, bytes: 32'd0, len: 3'd0};

  // sequencer
  seq_t seq, seq_next;

  // parse state
  parse_t          parse;
  logic [CW-1:0]   count;
  logic [3:0][7:0] ub;      // first bytes of a UTF-8 sequence

  // byte under decode; 'O' replay queues the original byte behind it
  logic [7:0]    cur;
  logic [7:0]    q_byte;
  logic          q_valid;
  logic          replay;
  logic [CW-1:0] idx;
  logic [CW-1:0] end_cnt;
  logic [CW-1:0] idx_inc;

  // pending-byte store
  logic [7:0] store_mem [STORE_BYTES];
  logic [7:0] rd_data;

  // events: hold keeps the newest one until it is known whether it is last
  result_t hold_res;
  logic    hold_valid;
  result_t out_res;
  logic    out_last;

  // step unit
  parse_t          st_parse;
  logic [CW-1:0]   st_count;
  logic [3:0][7:0] st_ub;
  logic [AW-1:0]   st_addr;
  result_t         st_res;
  step_ctl_t       st_ctl;

  logic    in_xfer;
  logic    out_free;
  logic    adv;
  logic    emit_req;
  result_t emit_res;
  logic    load_out;
  logic    load_last;

  tksd_step #(
    .STORE_BYTES (STORE_BYTES),
    .CW          (CW),
    .AW          (AW)
  ) u_step (
    .parse_in  (parse),
    .count_in  (count),
    .ub_in     (ub),
    .byte_in   (cur),
    .parse_out (st_parse),
    .count_out (st_count),
    .ub_out    (st_ub),
    .wr_addr   (st_addr),
    .res       (st_res),
    .ctl       (st_ctl)
  );

  assign in_ready = (seq == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign idx_inc  = idx + 1'b1;

  assign key_code   = out_res.key;
  assign codepoint  = out_res.cp;
  assign utf8_bytes = out_res.bytes;
  assign utf8_len   = out_res.len;
  assign last       = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= S_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  // next state and strobes
  always_comb begin
    seq_next  = seq;
    adv       = 1'b0;
    emit_req  = 1'b0;
    emit_res  = st_res;
    load_out  = 1'b0;
    load_last = 1'b0;
    case (seq)
      S_IDLE: begin
        if (in_valid) begin
          if (!op) begin
            seq_next = S_STEP;
          end else if (parse.phase != PH_IDLE && parse.phase != PH_UTF8) begin
            seq_next = S_TMO;
          end
        end
      end
      S_TMO: begin
        // pending ESC becomes Esc; the bytes after it get replayed
        emit_req = 1'b1;
        emit_res = ESC_RES;
        if (!hold_valid || out_free) begin
          adv      = 1'b1;
          seq_next = (end_cnt > CW'(1)) ? S_RD : S_FLUSH;
        end
      end
      S_STEP: begin
        emit_req = st_ctl.emit;
        emit_res = st_res;
        if (!emit_req || !hold_valid || out_free) begin
          adv = 1'b1;
          if (st_ctl.again || st_ctl.again_o || q_valid) begin
            seq_next = S_STEP;
          end else if (replay && idx_inc < end_cnt) begin
            seq_next = S_RD;
          end else begin
            seq_next = S_FLUSH;
          end
        end
      end
      S_RD:   seq_next = S_LOAD;
      S_LOAD: seq_next = S_STEP;
      S_FLUSH: begin
        if (!hold_valid) begin
          seq_next = S_IDLE;
        end else if (out_free) begin
          load_out  = 1'b1;
          load_last = 1'b1;
          seq_next  = S_IDLE;
        end
      end
      default: seq_next = S_IDLE;
    endcase
    // a new event pushes the held one out, not last
    if (adv && emit_req && hold_valid) load_out = 1'b1;
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse      <= PARSE_CLR;
      count      <= '0;
      q_valid    <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_xfer) begin
        cur     <= in_byte;
        replay  <= op;
        idx     <= CW'(1);
        end_cnt <= count;
        q_valid <= 1'b0;
      end

      if (seq == S_TMO && adv) begin
        parse <= PARSE_CLR;
        count <= '0;
      end

      if (seq == S_STEP && adv) begin
        parse <= st_parse;
        count <= st_count;
        ub    <= st_ub;
        if (st_ctl.again) begin
          cur <= cur;
        end else if (st_ctl.again_o) begin
          q_byte  <= cur;
          q_valid <= 1'b1;
          cur     <= CH_O;
        end else if (q_valid) begin
          cur     <= q_byte;
          q_valid <= 1'b0;
        end else if (replay) begin
          idx <= idx_inc;
        end
      end

      if (seq == S_LOAD) cur <= rd_data;

      if (adv && emit_req) begin
        hold_res   <= emit_res;
        hold_valid <= 1'b1;
      end else if (load_out) begin
        hold_valid <= 1'b0;
      end

      if (out_valid && out_ready) out_valid <= 1'b0;
      if (load_out) begin
        out_valid <= 1'b1;
        out_res   <= hold_res;
        out_last  <= load_last;
      end
    end
  end

  // store: written by decode steps, read during a replay; replay writes
  // never overtake the read position
  always_ff @(posedge clk) begin
    if (seq == S_STEP && adv && st_ctl.wr) store_mem[st_addr] <= cur;
    if (seq == S_RD) rd_data <= store_mem[idx[AW-1:0]];
  end

endmodule
